[rtl/dhkt_pkg.sv]
// Package for the double-hash key table: beat field widths, action and status
// codes, and the controller state type. No dependencies.
package dhkt_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 10;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_GET    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_CHECK,
    S_DONE
  } dhkt_state_t;

endpackage

[rtl/double_hash_key_table_top.sv]
// Double-hash key table: open-addressing map from keys to values in one slot memory.
// Depends on dhkt_pkg.
//
// channel | dir | tdata fields (low bit up)
// in_     | in  | action[1:0], key[33:2], value[49:34], zero fill to 56 bits
// out_    | out | status[1:0], value_out[17:2], live_count[27:18], zero fill to 32
//
// One item at a time. Insert, remove and get first reduce the key, min(KEY_BITS, 32) bits
// wide, four bits a cycle, then probe slots: each probe is one read and one check on the
// single slot memory port. An insert once the table is three quarters full, a get on an
// empty table and an unknown action skip the hash and the probes and go to the result.
// After reset a clearing pass zeroes every slot of the memory; in_tready is low until it ends.
// The result register frees the core while a beat waits on out_tready.
module double_hash_key_table_top
  import dhkt_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 1021,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // action[1:0], key[33:2], value[49:34]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // status[1:0], value_out[17:2], live_count[27:18]
);

  localparam int unsigned KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned VW   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int unsigned MW   = $clog2(TABLE_SIZE);
  localparam int unsigned CW   = $clog2(TABLE_SIZE + 1);
  localparam int unsigned NDIG = (KW + 3) / 4;
  localparam int unsigned KP   = NDIG * 4;
  localparam int unsigned DGW  = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int unsigned WW   = 2 + KW + VW;

  localparam logic [CW-1:0]  FULL_MARK = CW'(TABLE_SIZE * 3 / 4);
  localparam logic [CW-1:0]  LAST_PRB  = CW'(TABLE_SIZE - 1);
  localparam logic [MW:0]    MOD_A     = (MW + 1)'(TABLE_SIZE);
  localparam logic [MW:0]    MOD_B     = (MW + 1)'(TABLE_SIZE - 2);
  localparam logic [MW-1:0]  LAST_SLOT = MW'(TABLE_SIZE - 1);
  localparam logic [DGW-1:0] LAST_DIG  = DGW'(NDIG - 1);

  // slot word: {used, live, key, value}
  logic [WW-1:0] slot_mem [TABLE_SIZE];
  logic [WW-1:0] rd_data_r;
  logic [MW-1:0] mem_addr;
  logic          mem_we;
  logic [WW-1:0] mem_wdata;

  dhkt_state_t   state_r, state_nxt;
  logic [MW-1:0] clr_addr_r, clr_addr_nxt;
  logic [ACTION_W-1:0] act_r, act_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [VW-1:0] val_r, val_nxt;
  logic [KP-1:0] key_sh_r, key_sh_nxt;
  logic [DGW-1:0] dig_r, dig_nxt;
  logic [MW-1:0] pos_r, pos_nxt;
  logic [MW-1:0] step_r, step_nxt;
  logic [CW-1:0] probe_r, probe_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [VW-1:0] found_r, found_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [VW-1:0]       out_value_r, out_value_nxt;
  logic [CW-1:0]       out_count_r, out_count_nxt;

  logic [ACTION_W-1:0] in_action;
  logic [KW-1:0]       in_key;
  logic [VW-1:0]       in_value;

  logic          w_used, w_live;
  logic [KW-1:0] w_key;
  logic [VW-1:0] w_val;
  logic          key_hit;

  logic [MW:0]   red_a, red_b;
  logic [MW-1:0] rem_a, rem_b;
  logic [MW:0]   pos_sum;
  logic [MW-1:0] pos_next;

  assign in_action = in_tdata[1:0];
  assign in_key    = in_tdata[2 +: KW];
  assign in_value  = in_tdata[34 +: VW];

  assign {w_used, w_live, w_key, w_val} = rd_data_r;
  assign key_hit = (w_key == key_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, COUNT_W'(out_count_r), VALUE_W'(out_value_r), out_status_r};

  // one four-bit key digit a cycle, reduced by both moduli in parallel
  always_comb begin
    rem_a = pos_r;
    rem_b = step_r;
    red_a = '0;
    red_b = '0;
    for (int d = 0; d < 4; d++) begin
      red_a = {rem_a, key_sh_r[KP-1-d]};
      if (red_a >= MOD_A) begin
        red_a = red_a - MOD_A;
      end
      rem_a = red_a[MW-1:0];
      red_b = {rem_b, key_sh_r[KP-1-d]};
      if (red_b >= MOD_B) begin
        red_b = red_b - MOD_B;
      end
      rem_b = red_b[MW-1:0];
    end
  end

  always_comb begin
    pos_sum = {1'b0, pos_r} + {1'b0, step_r};
    if (pos_sum >= MOD_A) begin
      pos_sum = pos_sum - MOD_A;
    end
    pos_next = pos_sum[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= slot_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    key_sh_r     <= key_sh_nxt;
    dig_r        <= dig_nxt;
    pos_r        <= pos_nxt;
    step_r       <= step_nxt;
    probe_r      <= probe_nxt;
    status_r     <= status_nxt;
    found_r      <= found_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    key_sh_nxt     = key_sh_r;
    dig_nxt        = dig_r;
    pos_nxt        = pos_r;
    step_nxt       = step_r;
    probe_nxt      = probe_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    found_nxt      = found_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    mem_addr       = pos_r;
    mem_we         = 1'b0;
    mem_wdata      = rd_data_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_addr     = clr_addr_r;
        mem_we       = 1'b1;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt    = in_action;
          key_nxt    = in_key;
          val_nxt    = in_value;
          key_sh_nxt = KP'(in_key);
          dig_nxt    = '0;
          pos_nxt    = '0;
          step_nxt   = '0;
          probe_nxt  = '0;
          found_nxt  = '0;
          status_nxt = ST_MISS;
          if (in_action == ACT_INSERT && count_r >= FULL_MARK) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else if (in_action == ACT_GET && count_r == '0) begin
            state_nxt = S_DONE;
          end else if (in_action != ACT_INSERT && in_action != ACT_REMOVE
                       && in_action != ACT_GET) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        pos_nxt    = rem_a;
        step_nxt   = rem_b;
        key_sh_nxt = key_sh_r << 4;
        dig_nxt    = dig_r + 1'b1;
        if (dig_r == LAST_DIG) begin
          step_nxt  = rem_b + 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_DONE;
        unique case (act_r)
          ACT_INSERT: begin
            if (w_live && key_hit) begin
              mem_we     = 1'b1;
              mem_wdata  = {w_used, w_live, w_key, val_r};
              status_nxt = ST_OK;
            end else if (!w_live) begin
              mem_we     = 1'b1;
              mem_wdata  = {1'b1, 1'b1, key_r, val_r};
              count_nxt  = count_r + 1'b1;
              status_nxt = ST_OK;
            end else begin
              state_nxt = S_PROBE;
            end
          end
          ACT_REMOVE: begin
            if (!w_used) begin
              status_nxt = ST_MISS;
            end else if (key_hit) begin
              if (w_live) begin
                mem_we     = 1'b1;
                mem_wdata  = {w_used, 1'b0, w_key, w_val};
                if (count_r != '0) begin
                  count_nxt = count_r - 1'b1;
                end
                found_nxt  = w_val;
                status_nxt = ST_OK;
              end else begin
                status_nxt = ST_MISS;
              end
            end else begin
              state_nxt = S_PROBE;
            end
          end
          ACT_GET: begin
            if (key_hit) begin
              if (w_live) begin
                found_nxt  = w_val;
                status_nxt = ST_OK;
              end else begin
                status_nxt = ST_MISS;
              end
            end else if (!w_live) begin
              status_nxt = ST_MISS;
            end else begin
              state_nxt = S_PROBE;
            end
          end
          default: begin
            status_nxt = ST_MISS;
          end
        endcase
        if (state_nxt == S_PROBE) begin
          if (probe_r == LAST_PRB) begin
            status_nxt = (act_r == ACT_INSERT) ? ST_FULL : ST_MISS;
            state_nxt  = S_DONE;
          end else begin
            probe_nxt = probe_r + 1'b1;
            pos_nxt   = pos_next;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_value_nxt  = found_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
